/* hw/rtl/bpc_pkg.sv */
`default_nettype none

package bpc_pkg;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } in_item_t;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic        [16:0] pressure_pa;
        logic               clamped;
    } out_item_t;

    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] off_base;
        logic [15:0] sens_tempco;
        logic [15:0] off_tempco;
        logic [15:0] ref_temp_word;
        logic [15:0] temp_slope;
    } cal_t;

    typedef enum logic [2:0] {
        CFG_SENS_BASE     = 3'd0,
        CFG_OFF_BASE      = 3'd1,
        CFG_SENS_TEMPCO   = 3'd2,
        CFG_OFF_TEMPCO    = 3'd3,
        CFG_REF_TEMP_WORD = 3'd4,
        CFG_TEMP_SLOPE    = 3'd5
    } cfg_idx_t;

    localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
    localparam logic signed [18:0] VLOW_SHIFT = 19'sd3500;
    localparam logic signed [19:0] TEMP_LOW   = -20'sd4000;
    localparam logic signed [19:0] TEMP_HIGH  = 20'sd8500;
    localparam logic        [16:0] PRES_HIGH  = 17'h1FFFF;

endpackage

`default_nettype wire

/* hw/rtl/bpc_cfg_regs.sv */
`default_nettype none

module bpc_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output bpc_pkg::cal_t      cal
);

    bpc_pkg::cal_t cal_reg;
    bpc_pkg::cal_t cal_next;

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bpc_pkg::CFG_SENS_BASE:     cal_next.sens_base     = cfg_data;
                bpc_pkg::CFG_OFF_BASE:      cal_next.off_base      = cfg_data;
                bpc_pkg::CFG_SENS_TEMPCO:   cal_next.sens_tempco   = cfg_data;
                bpc_pkg::CFG_OFF_TEMPCO:    cal_next.off_tempco    = cfg_data;
                bpc_pkg::CFG_REF_TEMP_WORD: cal_next.ref_temp_word = cfg_data;
                bpc_pkg::CFG_TEMP_SLOPE:    cal_next.temp_slope    = cfg_data;
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/baro_pressure_temp_compensation_core.sv */
`default_nettype none

// Eight-register pipeline: done pulses as the item taken with start reaches result_reg.
// Throughput one transaction per cycle; busy stays low, results cannot be stalled.
// Rate is set by the four-multiplier product stage and the split 24x40 pressure product.
// Reset clears all valid bits and the calibration words to zero; no clearing pass.
module baro_pressure_temp_compensation_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire bpc_pkg::in_item_t item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic                   done,
    output bpc_pkg::out_item_t     result
);

    bpc_pkg::cal_t cal;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    assign busy = 1'b0;

    logic [7:0] vld_reg;
    logic [7:0] vld_next;

    // stage 1
    logic        [23:0] d1_s1_reg;
    logic signed [24:0] dt_s1_reg, dt_s1_next;
    // stage 2
    logic        [23:0] d1_s2_reg;
    logic signed [41:0] dtc6_reg, dtc6_next;
    logic signed [41:0] offt_reg, offt_next;
    logic signed [41:0] senst_reg, senst_next;
    logic signed [49:0] dtsq_reg, dtsq_next;
    // stage 3
    logic        [23:0] d1_s3_reg;
    logic signed [18:0] x_s3_reg, x_s3_next;
    logic signed [18:0] y_s3_reg, y_s3_next;
    logic signed [19:0] temp_s3_reg, temp_s3_next;
    logic signed [35:0] off_s3_reg, off_s3_next;
    logic signed [35:0] sens_s3_reg, sens_s3_next;
    logic        [17:0] t2_s3_reg, t2_s3_next;
    logic               low_s3_reg, vlow_s3_reg;
    // stage 4
    logic        [23:0] d1_s4_reg;
    logic signed [37:0] sqa_full, sqb_full;
    logic        [35:0] sqa_reg, sqb_reg;
    logic signed [19:0] temp_s4_reg;
    logic signed [35:0] off_s4_reg;
    logic signed [35:0] sens_s4_reg;
    logic        [17:0] t2_s4_reg;
    logic               low_s4_reg, vlow_s4_reg;
    // stage 5
    logic        [37:0] a5;
    logic        [38:0] b7, b11;
    logic        [39:0] off2, sens2;
    logic        [23:0] d1_s5_reg;
    logic signed [19:0] temp_s5_reg, temp_s5_next;
    logic signed [39:0] off_s5_reg, off_s5_next;
    logic signed [39:0] sens_s5_reg, sens_s5_next;
    // stage 6
    logic        [43:0] plo_reg, plo_next;
    logic signed [44:0] phi_reg, phi_next;
    logic signed [39:0] off_s6_reg;
    logic signed [14:0] temp_s6_reg, temp_s6_next;
    logic               tclamp_s6_reg, tclamp_s6_next;
    // stage 7
    logic signed [64:0] prod_reg, prod_next;
    logic signed [39:0] off_s7_reg;
    logic signed [14:0] temp_s7_reg;
    logic               tclamp_s7_reg;
    // output
    logic signed [44:0] pdiff;
    logic        [29:0] p_raw;
    logic               p_neg, p_big;
    bpc_pkg::out_item_t result_reg, result_next;

    assign vld_next = {vld_reg[6:0], start};

    assign dt_s1_next = $signed({1'b0, item.raw_temperature})
                      - $signed({1'b0, cal.ref_temp_word, 8'h00});

    assign dtc6_next  = dt_s1_reg * $signed({1'b0, cal.temp_slope});
    assign offt_next  = dt_s1_reg * $signed({1'b0, cal.off_tempco});
    assign senst_next = dt_s1_reg * $signed({1'b0, cal.sens_tempco});
    assign dtsq_next  = dt_s1_reg * dt_s1_reg;

    assign x_s3_next    = $signed(dtc6_reg[41:23]);
    assign temp_s3_next = $signed({x_s3_next[18], x_s3_next}) + bpc_pkg::TEMP_REF;
    assign y_s3_next    = x_s3_next + bpc_pkg::VLOW_SHIFT;
    assign off_s3_next  = $signed({4'b0000, cal.off_base, 16'h0000})
                        + $signed({offt_reg[41], offt_reg[41:7]});
    assign sens_s3_next = $signed({5'b00000, cal.sens_base, 15'h0000})
                        + $signed({{2{senst_reg[41]}}, senst_reg[41:8]});
    assign t2_s3_next   = x_s3_next[18] ? dtsq_reg[48:31] : 18'd0;

    assign sqa_full = x_s3_reg * x_s3_reg;
    assign sqb_full = y_s3_reg * y_s3_reg;

    always_comb
    begin
        a5    = {2'b00, sqa_reg} + {sqa_reg, 2'b00};
        b7    = {sqb_reg, 3'b000} - {3'b000, sqb_reg};
        b11   = {sqb_reg, 3'b000} + {2'b00, sqb_reg, 1'b0} + {3'b000, sqb_reg};
        off2  = (low_s4_reg ? {3'b000, a5[37:1]} : 40'd0)
              + (vlow_s4_reg ? {1'b0, b7} : 40'd0);
        sens2 = (low_s4_reg ? {4'b0000, a5[37:2]} : 40'd0)
              + (vlow_s4_reg ? {2'b00, b11[38:1]} : 40'd0);
        off_s5_next  = $signed({{4{off_s4_reg[35]}}, off_s4_reg}) - $signed(off2);
        sens_s5_next = $signed({{4{sens_s4_reg[35]}}, sens_s4_reg}) - $signed(sens2);
        temp_s5_next = temp_s4_reg - $signed({2'b00, t2_s4_reg});
    end

    assign plo_next = d1_s5_reg * sens_s5_reg[19:0];
    assign phi_next = $signed({1'b0, d1_s5_reg}) * $signed(sens_s5_reg[39:20]);

    always_comb
    begin
        tclamp_s6_next = 1'b0;
        temp_s6_next   = temp_s5_reg[14:0];
        if (temp_s5_reg < bpc_pkg::TEMP_LOW)
        begin
            temp_s6_next   = bpc_pkg::TEMP_LOW[14:0];
            tclamp_s6_next = 1'b1;
        end
        if (temp_s5_reg > bpc_pkg::TEMP_HIGH)
        begin
            temp_s6_next   = bpc_pkg::TEMP_HIGH[14:0];
            tclamp_s6_next = 1'b1;
        end
    end

    assign prod_next = $signed({phi_reg, 20'h00000}) + $signed({21'd0, plo_reg});

    always_comb
    begin
        pdiff = $signed({prod_reg[64], prod_reg[64:21]})
              - $signed({{5{off_s7_reg[39]}}, off_s7_reg});
        p_raw = pdiff[44:15];
        p_neg = p_raw[29];
        p_big = !p_neg && (|p_raw[28:17]);
        result_next.temp_centi  = temp_s7_reg;
        result_next.pressure_pa = p_neg ? 17'd0 : (p_big ? bpc_pkg::PRES_HIGH : p_raw[16:0]);
        result_next.clamped     = p_neg | p_big | tclamp_s7_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_s1_reg     <= item.raw_pressure;
        dt_s1_reg     <= dt_s1_next;

        d1_s2_reg     <= d1_s1_reg;
        dtc6_reg      <= dtc6_next;
        offt_reg      <= offt_next;
        senst_reg     <= senst_next;
        dtsq_reg      <= dtsq_next;

        d1_s3_reg     <= d1_s2_reg;
        x_s3_reg      <= x_s3_next;
        y_s3_reg      <= y_s3_next;
        temp_s3_reg   <= temp_s3_next;
        off_s3_reg    <= off_s3_next;
        sens_s3_reg   <= sens_s3_next;
        t2_s3_reg     <= t2_s3_next;
        low_s3_reg    <= x_s3_next[18];
        vlow_s3_reg   <= y_s3_next[18];

        d1_s4_reg     <= d1_s3_reg;
        sqa_reg       <= sqa_full[35:0];
        sqb_reg       <= sqb_full[35:0];
        temp_s4_reg   <= temp_s3_reg;
        off_s4_reg    <= off_s3_reg;
        sens_s4_reg   <= sens_s3_reg;
        t2_s4_reg     <= t2_s3_reg;
        low_s4_reg    <= low_s3_reg;
        vlow_s4_reg   <= vlow_s3_reg;

        d1_s5_reg     <= d1_s4_reg;
        temp_s5_reg   <= temp_s5_next;
        off_s5_reg    <= off_s5_next;
        sens_s5_reg   <= sens_s5_next;

        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        off_s6_reg    <= off_s5_reg;
        temp_s6_reg   <= temp_s6_next;
        tclamp_s6_reg <= tclamp_s6_next;

        prod_reg      <= prod_next;
        off_s7_reg    <= off_s6_reg;
        temp_s7_reg   <= temp_s6_reg;
        tclamp_s7_reg <= tclamp_s6_reg;

        result_reg    <= result_next;
    end

    assign done   = vld_reg[7];
    assign result = result_reg;

endmodule

`default_nettype wire
